### design/chip8eu_pkg.sv
// ----------------------------------------------------------------------------
// chip8eu_pkg
// Instruction numbers, fixed widths and the execute result record shared by
// the CHIP-8 execute unit modules.
// ----------------------------------------------------------------------------
package chip8eu_pkg;

   localparam int FUNC_W  = 6;
   localparam int ADDR_W  = 12;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 16;
   localparam int VREG_AW = 4;

   localparam logic [VREG_AW-1:0] VREG_FLAG = 4'hF;
   localparam logic [ADDR_W-1:0]  RESET_PC  = 12'd512;

   // Instruction numbers
   localparam logic [FUNC_W-1:0] FN_RET      = 6'd1;
   localparam logic [FUNC_W-1:0] FN_JP       = 6'd3;
   localparam logic [FUNC_W-1:0] FN_CALL     = 6'd4;
   localparam logic [FUNC_W-1:0] FN_SE_KK    = 6'd5;
   localparam logic [FUNC_W-1:0] FN_SNE_KK   = 6'd6;
   localparam logic [FUNC_W-1:0] FN_SE_VY    = 6'd7;
   localparam logic [FUNC_W-1:0] FN_LD_KK    = 6'd8;
   localparam logic [FUNC_W-1:0] FN_ADD_KK   = 6'd9;
   localparam logic [FUNC_W-1:0] FN_LD_VY    = 6'd10;
   localparam logic [FUNC_W-1:0] FN_OR       = 6'd11;
   localparam logic [FUNC_W-1:0] FN_AND      = 6'd12;
   localparam logic [FUNC_W-1:0] FN_XOR      = 6'd13;
   localparam logic [FUNC_W-1:0] FN_ADD_VY   = 6'd14;
   localparam logic [FUNC_W-1:0] FN_SUB      = 6'd15;
   localparam logic [FUNC_W-1:0] FN_SHR      = 6'd16;
   localparam logic [FUNC_W-1:0] FN_SUBN     = 6'd17;
   localparam logic [FUNC_W-1:0] FN_SHL      = 6'd18;
   localparam logic [FUNC_W-1:0] FN_SNE_VY   = 6'd19;
   localparam logic [FUNC_W-1:0] FN_LD_I     = 6'd20;
   localparam logic [FUNC_W-1:0] FN_JP_V0    = 6'd21;
   localparam logic [FUNC_W-1:0] FN_LD_VX_DT = 6'd26;
   localparam logic [FUNC_W-1:0] FN_LD_DT_VX = 6'd28;
   localparam logic [FUNC_W-1:0] FN_LD_ST_VX = 6'd29;
   localparam logic [FUNC_W-1:0] FN_ADD_I    = 6'd30;

   // Result of executing one instruction
   typedef struct packed {
      logic               wr_en;      // write Vx
      logic [BYTE_W-1:0]  wr_data;
      logic               flag_set;   // write VF after Vx
      logic [BYTE_W-1:0]  flag_data;
      logic [ADDR_W-1:0]  pc;
      logic [INDEX_W-1:0] index;
      logic [BYTE_W-1:0]  delay;      // after decrement
      logic [BYTE_W-1:0]  sound;      // after decrement
      logic               is_call;
      logic               is_ret;
   } exec_result_type;

endpackage

### design/chip8eu_vreg_file.sv
// ----------------------------------------------------------------------------
// chip8eu_vreg_file
// V register memory: two registered read ports, one write port, write-first
// bypass, per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module chip8eu_vreg_file
   import chip8eu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [VREG_AW-1:0] rd_addr_a,
   input  logic [VREG_AW-1:0] rd_addr_b,
   input  logic               wr_en,
   input  logic [VREG_AW-1:0] wr_addr,
   input  logic [BYTE_W-1:0]  wr_data,
   output logic [BYTE_W-1:0]  rd_data_a,
   output logic [BYTE_W-1:0]  rd_data_b
);

   localparam int DEPTH = 1 << VREG_AW;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DEPTH-1:0]  vld_in;
   logic [BYTE_W-1:0] rd_a_ff;
   logic [BYTE_W-1:0] rd_b_ff;

   // Mark written entries
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports, forward a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr_a)) begin
            rd_a_ff <= wr_data;
         end else begin
            rd_a_ff <= vld_ff[rd_addr_a] ? mem[rd_addr_a] : '0;
         end
         if (wr_en && (wr_addr == rd_addr_b)) begin
            rd_b_ff <= wr_data;
         end else begin
            rd_b_ff <= vld_ff[rd_addr_b] ? mem[rd_addr_b] : '0;
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### design/chip8eu_ret_stack.sv
// ----------------------------------------------------------------------------
// chip8eu_ret_stack
// Return-address memory: one registered read port, one write port,
// write-first bypass, per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module chip8eu_ret_stack
   import chip8eu_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int SP_W  = 4
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [SP_W-1:0]   rd_addr,
   input  logic              wr_en,
   input  logic [SP_W-1:0]   wr_addr,
   input  logic [ADDR_W-1:0] wr_data,
   output logic [ADDR_W-1:0] rd_data
);

   logic [ADDR_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DEPTH-1:0]  vld_in;
   logic [ADDR_W-1:0] rd_ff;

   // Mark written entries
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, forward a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

### design/chip8eu_alu.sv
// ----------------------------------------------------------------------------
// chip8eu_alu
// Executes one decoded instruction against the operand values and the
// current scalar state; timers count down after the instruction.
// ----------------------------------------------------------------------------
module chip8eu_alu
   import chip8eu_pkg::*;
(
   input  logic [FUNC_W-1:0]  func,
   input  logic [ADDR_W-1:0]  op_one,
   input  logic [ADDR_W-1:0]  op_two,
   input  logic [BYTE_W-1:0]  vx,
   input  logic [BYTE_W-1:0]  vy,
   input  logic [ADDR_W-1:0]  pc,
   input  logic [INDEX_W-1:0] index,
   input  logic [BYTE_W-1:0]  delay,
   input  logic [BYTE_W-1:0]  sound,
   input  logic [ADDR_W-1:0]  ret_addr,
   output exec_result_type    res
);

   logic [BYTE_W-1:0] kk;
   logic [BYTE_W:0]   sum;
   logic [ADDR_W-1:0] pc_skip;
   logic [BYTE_W-1:0] delay_set;
   logic [BYTE_W-1:0] sound_set;

   assign kk      = op_two[BYTE_W-1:0];
   assign sum     = {1'b0, vx} + {1'b0, (func == FN_ADD_KK) ? kk : vy};
   assign pc_skip = pc + ADDR_W'(2);

   always_comb begin
      res.wr_en     = 1'b0;
      res.wr_data   = '0;
      res.flag_set  = 1'b0;
      res.flag_data = '0;
      res.pc        = pc;
      res.index     = index;
      res.is_call   = 1'b0;
      res.is_ret    = 1'b0;
      delay_set     = delay;
      sound_set     = sound;

      unique case (func)
         FN_RET: begin
            res.is_ret = 1'b1;
            res.pc     = ret_addr;
         end
         FN_JP: begin
            res.pc = op_one;
         end
         FN_CALL: begin
            res.is_call = 1'b1;
            res.pc      = op_two;
         end
         FN_SE_KK: begin
            if (vx == kk) res.pc = pc_skip;
         end
         FN_SNE_KK: begin
            if (vx != kk) res.pc = pc_skip;
         end
         FN_SE_VY: begin
            if (vx == vy) res.pc = pc_skip;
         end
         FN_SNE_VY: begin
            if (vx != vy) res.pc = pc_skip;
         end
         FN_LD_KK: begin
            res.wr_en   = 1'b1;
            res.wr_data = kk;
         end
         FN_ADD_KK: begin
            res.wr_en   = 1'b1;
            res.wr_data = sum[BYTE_W-1:0];
         end
         FN_LD_VY: begin
            res.wr_en   = 1'b1;
            res.wr_data = vy;
         end
         FN_OR: begin
            res.wr_en   = 1'b1;
            res.wr_data = vx | vy;
         end
         FN_AND: begin
            res.wr_en   = 1'b1;
            res.wr_data = vx & vy;
         end
         FN_XOR: begin
            res.wr_en   = 1'b1;
            res.wr_data = vx ^ vy;
         end
         FN_ADD_VY: begin
            res.wr_en     = 1'b1;
            res.wr_data   = sum[BYTE_W-1:0];
            res.flag_set  = 1'b1;
            res.flag_data = BYTE_W'(sum[BYTE_W]);
         end
         FN_SUB: begin
            res.wr_en     = 1'b1;
            res.wr_data   = vx - vy;
            res.flag_set  = 1'b1;
            res.flag_data = BYTE_W'(vx > vy);
         end
         FN_SHR: begin
            res.wr_en     = 1'b1;
            res.wr_data   = vx >> 1;
            res.flag_set  = 1'b1;
            res.flag_data = BYTE_W'(vx[0]);
         end
         FN_SUBN: begin
            res.wr_en     = 1'b1;
            res.wr_data   = vy - vx;
            res.flag_set  = 1'b1;
            res.flag_data = BYTE_W'(vy > vx);
         end
         FN_SHL: begin
            res.wr_en     = 1'b1;
            res.wr_data   = vx << 1;
            res.flag_set  = 1'b1;
            res.flag_data = BYTE_W'(vx[BYTE_W-1]);
         end
         FN_LD_I: begin
            res.index = INDEX_W'(op_two);
         end
         FN_JP_V0: begin
            // vy carries V0 for this instruction
            res.pc = op_two + ADDR_W'(vy);
         end
         FN_LD_VX_DT: begin
            res.wr_en   = 1'b1;
            res.wr_data = delay;
         end
         FN_LD_DT_VX: begin
            delay_set = vx;
         end
         FN_LD_ST_VX: begin
            sound_set = vx;
         end
         FN_ADD_I: begin
            res.index = index + INDEX_W'(vx);
         end
         default: begin
         end
      endcase

      // Count both timers down toward zero
      res.delay = (delay_set != '0) ? delay_set - BYTE_W'(1) : '0;
      res.sound = (sound_set != '0) ? sound_set - BYTE_W'(1) : '0;
   end

endmodule

### design/chip8_execute_unit.sv
// Stage 1 registers the instruction and its operand reads at the input transfer;
// the result is executed and registered in the output register as stage 1 advances.
// Throughput: one instruction per cycle unless output stalls; the V register memory
// is read on two ports, the return stack on one, each written at most once a cycle.
// Reset: synchronous, clears control state and valid bits at once (no clearing
// pass); PC loads 512, all other state reads as zero.
// ----------------------------------------------------------------------------
// chip8_execute_unit
// CHIP-8 instruction execute stage with V registers and return stack held in
// synchronous memories, VF and scalar state in flops.
// ----------------------------------------------------------------------------
module chip8_execute_unit
   import chip8eu_pkg::*;
#(
   parameter int STACK_DEPTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [ADDR_W-1:0]   csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ADDR_W-1:0]   req_op_one,
   input  logic [ADDR_W-1:0]   req_op_two,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ADDR_W-1:0]   rsp_next_pc,
   output logic [INDEX_W-1:0]  rsp_index_value,
   output logic [BYTE_W-1:0]   rsp_flag_value,
   output logic [BYTE_W-1:0]   rsp_delay_value,
   output logic                rsp_sound_on
);

   localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

   // Pipeline control
   logic               req_xfer;
   logic               s1_adv;
   logic               s1_vld_ff, s1_vld_in;
   logic               rsp_vld_ff, rsp_vld_in;

   logic [FUNC_W-1:0]  s1_func_ff;
   logic [ADDR_W-1:0]  s1_op1_ff;
   logic [ADDR_W-1:0]  s1_op2_ff;

   // Architectural state
   logic [ADDR_W-1:0]  pc_ff, pc_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [BYTE_W-1:0]  delay_ff, delay_in;
   logic [BYTE_W-1:0]  sound_ff, sound_in;
   logic [BYTE_W-1:0]  flag_ff, flag_in;

   // Memory interfaces
   logic [VREG_AW-1:0] rd_addr_b;
   logic [BYTE_W-1:0]  rd_a, rd_b;
   logic               vr_we;
   logic [SP_W-1:0]    stk_rd_addr;
   logic [ADDR_W-1:0]  stk_rd_data;

   logic               x_is_f, y_is_f;
   logic [BYTE_W-1:0]  vx, vy;
   exec_result_type    res;

   logic [ADDR_W-1:0]  rsp_pc_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [BYTE_W-1:0]  rsp_flag_ff;
   logic [BYTE_W-1:0]  rsp_delay_ff;
   logic               rsp_sound_ff;

   // Handshake: stage 1 moves on when the output register is free or drains
   assign s1_adv    = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign req_xfer  = req_valid && req_ready;

   assign s1_vld_in  = req_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);
   assign rsp_vld_in = s1_adv ? 1'b1 : ((rsp_vld_ff && rsp_ready) ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Capture instruction into stage 1
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_func_ff <= req_func;
         s1_op1_ff  <= req_op_one;
         s1_op2_ff  <= req_op_two;
      end
   end

   // Port B reads V0 for the indexed jump, Vy otherwise
   assign rd_addr_b = (req_func == FN_JP_V0) ? '0 : req_op_two[VREG_AW-1:0];

   // VF lives in flops; the memory copy of entry F is never used
   assign x_is_f = (s1_op1_ff[VREG_AW-1:0] == VREG_FLAG);
   assign y_is_f = (s1_op2_ff[VREG_AW-1:0] == VREG_FLAG) && (s1_func_ff != FN_JP_V0);
   assign vx     = x_is_f ? flag_ff : rd_a;
   assign vy     = y_is_f ? flag_ff : rd_b;
   assign vr_we  = s1_adv && res.wr_en && !x_is_f;

   chip8eu_vreg_file u_vregs (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_xfer),
      .rd_addr_a (req_op_one[VREG_AW-1:0]),
      .rd_addr_b (rd_addr_b),
      .wr_en     (vr_we),
      .wr_addr   (s1_op1_ff[VREG_AW-1:0]),
      .wr_data   (res.wr_data),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   chip8eu_alu u_alu (
      .func     (s1_func_ff),
      .op_one   (s1_op1_ff),
      .op_two   (s1_op2_ff),
      .vx       (vx),
      .vy       (vy),
      .pc       (pc_ff),
      .index    (index_ff),
      .delay    (delay_ff),
      .sound    (sound_ff),
      .ret_addr (stk_rd_data),
      .res      (res)
   );

   // Stack pointer wraps modulo the depth
   always_comb begin
      sp_in = sp_ff;
      if (s1_adv && res.is_ret) begin
         sp_in = (sp_ff == '0) ? SP_LAST : sp_ff - SP_W'(1);
      end else if (s1_adv && res.is_call) begin
         sp_in = (sp_ff == SP_LAST) ? '0 : sp_ff + SP_W'(1);
      end
   end

   // Prefetch the entry a return in the next instruction would pop
   assign stk_rd_addr = (sp_in == '0) ? SP_LAST : sp_in - SP_W'(1);

   chip8eu_ret_stack #(
      .DEPTH (STACK_DEPTH),
      .SP_W  (SP_W)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_addr (stk_rd_addr),
      .wr_en   (s1_adv && res.is_call),
      .wr_addr (sp_ff),
      .wr_data (pc_ff),
      .rd_data (stk_rd_data)
   );

   // Update scalar state; VF write lands after the Vx write
   always_comb begin
      pc_in    = pc_ff;
      index_in = index_ff;
      delay_in = delay_ff;
      sound_in = sound_ff;
      flag_in  = flag_ff;
      if (csr_we) begin
         pc_in = csr_wdata;
      end
      if (s1_adv) begin
         pc_in    = res.pc;
         index_in = res.index;
         delay_in = res.delay;
         sound_in = res.sound;
         if (res.flag_set) begin
            flag_in = res.flag_data;
         end else if (res.wr_en && x_is_f) begin
            flag_in = res.wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= RESET_PC;
         sp_ff    <= '0;
         index_ff <= '0;
         delay_ff <= '0;
         sound_ff <= '0;
         flag_ff  <= '0;
      end else begin
         pc_ff    <= pc_in;
         sp_ff    <= sp_in;
         index_ff <= index_in;
         delay_ff <= delay_in;
         sound_ff <= sound_in;
         flag_ff  <= flag_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pc_ff    <= pc_in;
         rsp_index_ff <= index_in;
         rsp_flag_ff  <= flag_in;
         rsp_delay_ff <= delay_in;
         rsp_sound_ff <= (sound_in != '0);
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_next_pc     = rsp_pc_ff;
   assign rsp_index_value = rsp_index_ff;
   assign rsp_flag_value  = rsp_flag_ff;
   assign rsp_delay_value = rsp_delay_ff;
   assign rsp_sound_on    = rsp_sound_ff;

`ifndef SYNTH
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) < STACK_DEPTH)
      else $error("stack pointer beyond depth");

   a_adv_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_vld_ff)
      else $error("executed instruction lost before output register");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && rsp_vld_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while pipeline is full");

   a_sound_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_sound_ff == (sound_ff != '0)))
      else $error("sound flag out of step with sound timer");
`endif

endmodule

### tb/chip8_execute_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_execute_unit_tb
// Drives decoded CHIP-8 instructions into the execute unit over the request
// channel and checks every response against an in-bench architectural
// predictor (V registers, PC, return stack, index and timers). Covers each
// instruction, flag aliasing on VF, PC and stack wrap, index wrap, start
// address writes, random idling on both channels and a long response stall.
// ----------------------------------------------------------------------------
module chip8_execute_unit_tb
   import chip8eu_pkg::*;
();

   localparam int STACK_DEPTH = 16;
   localparam int CYCLE_LIMIT = 250000;
   localparam int HOLD_CYCLES = 80;

   // Instruction numbers the unit treats as no-ops
   localparam logic [FUNC_W-1:0] FN_CLS   = 6'd0;
   localparam logic [FUNC_W-1:0] FN_SYS   = 6'd2;
   localparam logic [FUNC_W-1:0] FN_DRW   = 6'd23;
   localparam logic [FUNC_W-1:0] FN_LD_RD = 6'd34;
   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 6'd35;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 6'd63;

   typedef struct packed {
      logic [ADDR_W-1:0]  next_pc;
      logic [INDEX_W-1:0] index_value;
      logic [BYTE_W-1:0]  flag_value;
      logic [BYTE_W-1:0]  delay_value;
      logic               sound_on;
   } exec_outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [ADDR_W-1:0]   csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [ADDR_W-1:0]   req_op_one = '0;
   logic [ADDR_W-1:0]   req_op_two = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ADDR_W-1:0]   rsp_next_pc;
   logic [INDEX_W-1:0]  rsp_index_value;
   logic [BYTE_W-1:0]   rsp_flag_value;
   logic [BYTE_W-1:0]   rsp_delay_value;
   logic                rsp_sound_on;

   // Predicted architectural state
   logic [BYTE_W-1:0]  arch_vreg [16] = '{default: '0};
   logic [ADDR_W-1:0]  arch_stack [STACK_DEPTH] = '{default: '0};
   logic [ADDR_W-1:0]  arch_start = RESET_PC;
   logic [ADDR_W-1:0]  arch_pc = RESET_PC;
   int unsigned        arch_sp = 0;
   logic [INDEX_W-1:0] arch_index = '0;
   logic [BYTE_W-1:0]  arch_delay = '0;
   logic [BYTE_W-1:0]  arch_sound = '0;

   exec_outcome_type pending_outcomes[$];

   int  fail_count = 0;
   int  cycle_count = 0;
   bit  idle_on = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;

   chip8_execute_unit #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_op_one     (req_op_one),
      .req_op_two     (req_op_two),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_index_value(rsp_index_value),
      .rsp_flag_value (rsp_flag_value),
      .rsp_delay_value(rsp_delay_value),
      .rsp_sound_on   (rsp_sound_on)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Execute one instruction on the predicted state and queue the outcome
   task automatic chip8_predict(input logic [FUNC_W-1:0] fn,
                                input logic [ADDR_W-1:0] op_one,
                                input logic [ADDR_W-1:0] op_two);
      logic [3:0]        x;
      logic [3:0]        y;
      logic [BYTE_W-1:0] kk;
      logic [BYTE_W-1:0] vx;
      logic [BYTE_W-1:0] vy;
      logic [BYTE_W:0]   sum;
      exec_outcome_type  outcome;
      x   = op_one[3:0];
      y   = op_two[3:0];
      kk  = op_two[7:0];
      vx  = arch_vreg[x];
      vy  = arch_vreg[y];
      sum = {1'b0, vx} + {1'b0, vy};
      case (fn)
         FN_RET: begin
            arch_sp = (arch_sp + STACK_DEPTH - 1) % STACK_DEPTH;
            arch_pc = arch_stack[arch_sp];
         end
         FN_JP: arch_pc = op_one;
         FN_CALL: begin
            arch_stack[arch_sp] = arch_pc;
            arch_pc = op_two;
            arch_sp = (arch_sp + 1) % STACK_DEPTH;
         end
         FN_SE_KK:  if (vx == kk) arch_pc = arch_pc + 12'd2;
         FN_SNE_KK: if (vx != kk) arch_pc = arch_pc + 12'd2;
         FN_SE_VY:  if (vx == vy) arch_pc = arch_pc + 12'd2;
         FN_SNE_VY: if (vx != vy) arch_pc = arch_pc + 12'd2;
         FN_LD_KK:  arch_vreg[x] = kk;
         FN_ADD_KK: arch_vreg[x] = vx + kk;
         FN_LD_VY:  arch_vreg[x] = vy;
         FN_OR:     arch_vreg[x] = vx | vy;
         FN_AND:    arch_vreg[x] = vx & vy;
         FN_XOR:    arch_vreg[x] = vx ^ vy;
         // flag write goes last so VF as destination ends up holding the flag
         FN_ADD_VY: begin
            arch_vreg[x] = sum[BYTE_W-1:0];
            arch_vreg[VREG_FLAG] = {7'd0, sum[BYTE_W]};
         end
         FN_SUB: begin
            arch_vreg[x] = vx - vy;
            arch_vreg[VREG_FLAG] = {7'd0, vx > vy};
         end
         FN_SHR: begin
            arch_vreg[x] = vx >> 1;
            arch_vreg[VREG_FLAG] = {7'd0, vx[0]};
         end
         FN_SUBN: begin
            arch_vreg[x] = vy - vx;
            arch_vreg[VREG_FLAG] = {7'd0, vy > vx};
         end
         FN_SHL: begin
            arch_vreg[x] = vx << 1;
            arch_vreg[VREG_FLAG] = {7'd0, vx[7]};
         end
         FN_LD_I:     arch_index = {4'd0, op_two};
         FN_JP_V0:    arch_pc = {4'd0, arch_vreg[0]} + op_two;
         FN_LD_VX_DT: arch_vreg[x] = arch_delay;
         FN_LD_DT_VX: arch_delay = vx;
         FN_LD_ST_VX: arch_sound = vx;
         FN_ADD_I:    arch_index = arch_index + {8'd0, vx};
         default: ;
      endcase
      // count both timers down toward zero
      if (arch_delay != 0) arch_delay = arch_delay - 8'd1;
      if (arch_sound != 0) arch_sound = arch_sound - 8'd1;
      outcome.next_pc     = arch_pc;
      outcome.index_value = arch_index;
      outcome.flag_value  = arch_vreg[VREG_FLAG];
      outcome.delay_value = arch_delay;
      outcome.sound_on    = (arch_sound != 0);
      pending_outcomes.push_back(outcome);
   endtask

   // Offer one instruction and hold it until the transfer
   task automatic send_instr(input logic [FUNC_W-1:0] fn,
                             input logic [ADDR_W-1:0] op_one,
                             input logic [ADDR_W-1:0] op_two);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      chip8_predict(fn, op_one, op_two);
      req_func   <= fn;
      req_op_one <= op_one;
      req_op_two <= op_two;
      req_valid  <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and let every outstanding response arrive
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ADDR_W-1:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      arch_start = value;
      arch_pc    = arch_start;
   endtask

   // Random instruction, biased so that skips take both directions
   task automatic send_random_instr();
      logic [FUNC_W-1:0] fn;
      logic [ADDR_W-1:0] op_one;
      logic [ADDR_W-1:0] op_two;
      if ($urandom_range(0, 99) < 6)
         fn = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      else
         fn = FUNC_W'($urandom_range(0, FN_LD_RD));
      op_one = ADDR_W'($urandom_range(0, 4095));
      op_two = ADDR_W'($urandom_range(0, 4095));
      if ((fn == FN_SE_KK || fn == FN_SNE_KK) && $urandom_range(0, 1))
         op_two[7:0] = arch_vreg[op_one[3:0]];
      if ((fn == FN_SE_VY || fn == FN_SNE_VY) && $urandom_range(0, 1))
         op_two[3:0] = op_one[3:0];
      send_instr(fn, op_one, op_two);
   endtask

   task automatic check_field(input string name, input logic [15:0] expv,
                              input logic [15:0] actv);
      if (expv !== actv) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
         fail_count++;
      end
   endtask

   // Compare each response transfer with the oldest predicted outcome
   always @(posedge clock) begin
      exec_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual pc %h",
                     $time, rsp_next_pc);
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("next_pc", 16'(want.next_pc), 16'(rsp_next_pc));
            check_field("index_value", want.index_value, rsp_index_value);
            check_field("flag_value", 16'(want.flag_value), 16'(rsp_flag_value));
            check_field("delay_value", 16'(want.delay_value), 16'(rsp_delay_value));
            check_field("sound_on", 16'(want.sound_on), 16'(rsp_sound_on));
         end
      end
   end

   // Response side ready: long hold on request, else random stall bursts
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every instruction at least once, flag aliasing, PC wrap and timers
   task automatic test_directed();
      idle_on = 1'b1;
      send_instr(FN_CLS, 12'h000, 12'h000);
      send_instr(FN_RET, 12'hFFF, 12'hFFF);       // stack underflow
      send_instr(FN_JP, 12'hFFF, 12'h000);
      send_instr(FN_SE_VY, 12'h0A3, 12'h5B3);     // skip past 4095
      send_instr(FN_LD_KK, 12'hFF0, 12'hAFF);     // upper operand bits ignored
      send_instr(FN_LD_KK, 12'h001, 12'h001);
      send_instr(FN_ADD_VY, 12'h000, 12'h001);    // carry out
      send_instr(FN_ADD_VY, 12'h002, 12'h003);    // no carry clears VF
      send_instr(FN_ADD_KK, 12'h001, 12'h0FF);
      send_instr(FN_LD_KK, 12'h00F, 12'h080);
      send_instr(FN_SHL, 12'h00F, 12'h000);       // VF as destination
      send_instr(FN_LD_KK, 12'h004, 12'h081);
      send_instr(FN_SHR, 12'h004, 12'h000);
      send_instr(FN_SUB, 12'h004, 12'h004);       // equal operands
      send_instr(FN_LD_KK, 12'h007, 12'h0FF);
      send_instr(FN_SUBN, 12'h004, 12'h007);
      send_instr(FN_OR, 12'h005, 12'h004);
      send_instr(FN_AND, 12'h005, 12'h007);
      send_instr(FN_XOR, 12'h005, 12'h007);
      send_instr(FN_LD_VY, 12'h000, 12'h007);
      send_instr(FN_SE_KK, 12'h007, 12'h3FF);
      send_instr(FN_SNE_KK, 12'h007, 12'h0FF);
      send_instr(FN_SNE_VY, 12'h004, 12'h007);
      send_instr(FN_LD_I, 12'h000, 12'hFFF);
      send_instr(FN_ADD_I, 12'h007, 12'h000);
      send_instr(FN_JP_V0, 12'h000, 12'hFFF);     // V0 plus address wraps
      send_instr(FN_CALL, 12'h000, 12'hABC);
      send_instr(FN_RET, 12'h000, 12'h000);
      send_instr(FN_LD_DT_VX, 12'h007, 12'h000);
      send_instr(FN_LD_ST_VX, 12'h004, 12'h000);
      send_instr(FN_LD_VX_DT, 12'h008, 12'h000);
      send_instr(FN_SYS, 12'hFFF, 12'hFFF);
      send_instr(FN_DRW, 12'h123, 12'h456);
      send_instr(FN_UNUSED_HI, 12'hFFF, 12'hFFF);
      wait_drained();
   endtask

   // Nested calls past the stack depth, then unwind past the bottom
   task automatic test_call_stack();
      idle_on = 1'b1;
      repeat (STACK_DEPTH + 3)
         send_instr(FN_CALL, ADDR_W'($urandom_range(0, 4095)),
                    ADDR_W'($urandom_range(0, 4095)));
      repeat (STACK_DEPTH + 3)
         send_instr(FN_RET, ADDR_W'($urandom_range(0, 4095)),
                    ADDR_W'($urandom_range(0, 4095)));
      wait_drained();
   endtask

   // Add to the index until it wraps past 16 bits
   task automatic test_index_wrap();
      idle_on = 1'b1;
      send_instr(FN_LD_KK, 12'h0A5, 12'h0FF);
      send_instr(FN_LD_I, 12'h000, 12'hFFF);
      repeat (245)
         send_instr(FN_ADD_I, {8'($urandom_range(0, 255)), 4'h5}, 12'h000);
      wait_drained();
   endtask

   // Stall the response side long enough that the request side backs up
   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_request = 1'b1;
      repeat (30) send_random_instr();
      wait_drained();
   endtask

   // Random phases, each under its own start address
   task automatic test_random_phases();
      logic [ADDR_W-1:0] start_addr;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0)
            start_addr = '0;
         else if (phase == 1)
            start_addr = '1;
         else
            start_addr = ADDR_W'($urandom_range(0, 4095));
         csr_write(start_addr);
         idle_on = (phase != 2 && phase != 5);
         repeat (90) send_random_instr();
         wait_drained();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_call_stack();
      test_index_wrap();
      test_backpressure();
      test_random_phases();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
